/* hw/rtl/lsp_pkg.sv */
// Shared types and constants for the LIFO stack with peek and poke.
// No dependencies; used by every module under hw/rtl.
`default_nettype none

package lsp_pkg;

	// Fixed widths of the request, result and configuration fields
	localparam int ACT_W     = 3;
	localparam int VAL_W     = 32;
	localparam int POS_W     = 8;
	localparam int CNT_OUT_W = 9;
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 1;

	// Parameter defaults
	localparam int DEPTH_DEF      = 256;
	localparam int DATA_WIDTH_DEF = 32;

	// Configuration reset values
	localparam logic [CFG_W-1:0] INIT_CAP_RST  = 9'd256;
	localparam logic [CFG_W-1:0] GROW_STEP_RST = 9'd0;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_CAP  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GROW_STEP = 1'd1;

	// Request action codes
	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH    = 3'd0,
		ACT_POP     = 3'd1,
		ACT_POKE    = 3'd2,
		ACT_PEEK    = 3'd3,
		ACT_PEEK_AT = 3'd4
	} action_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RESULT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;  // latch a new request
		logic exec;     // update stack, access memory
		logic emit;     // result on the ports this cycle
	} cmd_t;

	// Configuration register contents
	typedef struct packed {
		logic [CFG_W-1:0] init_cap;
		logic [CFG_W-1:0] grow_step;
	} cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/lsp_cfg.sv */
// Configuration registers: initial capacity and growth step.
// Depends on lsp_pkg.
`default_nettype none

module lsp_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            we,
	input  wire logic [lsp_pkg::CFG_IDX_W-1:0]   idx,
	input  wire logic [lsp_pkg::CFG_W-1:0]       wdata,
	output lsp_pkg::cfg_t                        cfg
);

	logic [lsp_pkg::CFG_W-1:0] init_cap_q;
	logic [lsp_pkg::CFG_W-1:0] grow_step_q;

	// register writes, decoded by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_cap_q  <= lsp_pkg::INIT_CAP_RST;
			grow_step_q <= lsp_pkg::GROW_STEP_RST;
		end else if (we) begin
			case (idx)
				lsp_pkg::CFG_INIT_CAP:  init_cap_q  <= wdata;
				lsp_pkg::CFG_GROW_STEP: grow_step_q <= wdata;
				default: ;
			endcase
		end
	end

	assign cfg.init_cap  = init_cap_q;
	assign cfg.grow_step = grow_step_q;

endmodule

`default_nettype wire

/* hw/rtl/lsp_ctrl.sv */
// Controller state machine: sequences capture, execute and result of a request.
// Depends on lsp_pkg.
`default_nettype none

module lsp_ctrl (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	output logic          done,
	output lsp_pkg::cmd_t cmd
);

	lsp_pkg::state_t state_q;
	lsp_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lsp_pkg::ST_IDLE: begin
				if (start) state_d = lsp_pkg::ST_EXEC;
			end
			lsp_pkg::ST_EXEC: begin
				state_d = lsp_pkg::ST_RESULT;
			end
			lsp_pkg::ST_RESULT: begin
				state_d = start ? lsp_pkg::ST_EXEC : lsp_pkg::ST_IDLE;
			end
			default: begin
				state_d = lsp_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs; a new request may enter while the previous result is shown
	always_comb begin
		busy        = 1'b0;
		cmd.exec    = 1'b0;
		cmd.emit    = 1'b0;
		case (state_q)
			lsp_pkg::ST_IDLE:   ;
			lsp_pkg::ST_EXEC: begin
				busy     = 1'b1;
				cmd.exec = 1'b1;
			end
			lsp_pkg::ST_RESULT: begin
				cmd.emit = 1'b1;
			end
			default: ;
		endcase
		cmd.capture = start && !busy;
		done        = cmd.emit;
	end

endmodule

`default_nettype wire

/* hw/rtl/lsp_dp.sv */
// Datapath: request registers, stack memory, fill and growth counters, result.
// Depends on lsp_pkg.
`default_nettype none

module lsp_dp #(
	parameter int DEPTH      = lsp_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = lsp_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire lsp_pkg::cmd_t                   cmd,
	input  wire lsp_pkg::cfg_t                   cfg,
	input  wire logic [lsp_pkg::ACT_W-1:0]       action,
	input  wire logic [lsp_pkg::VAL_W-1:0]       value_in,
	input  wire logic [lsp_pkg::POS_W-1:0]       index,
	output logic [lsp_pkg::VAL_W-1:0]            value_out,
	output logic                                 value_valid,
	output logic [lsp_pkg::CNT_OUT_W-1:0]        returned_count,
	output logic                                 overflow
);

	localparam int VW     = lsp_pkg::VAL_W;
	localparam int CW     = lsp_pkg::CNT_OUT_W;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = ((CNT_W > lsp_pkg::CFG_W) ? CNT_W : lsp_pkg::CFG_W) + 1;
	localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);

	// request registers
	lsp_pkg::action_t             act_q;
	logic [DATA_WIDTH-1:0]        word_q;
	logic [lsp_pkg::POS_W-1:0]    pos_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q  <= lsp_pkg::action_t'(action);
			word_q <= DATA_WIDTH'(value_in);
			pos_q  <= index;
		end
	end

	// stack state
	logic [CNT_W-1:0] fill_q, fill_d, fill_m1;
	logic [CNT_W-1:0] grown_q, grown_d;

	// capacity before and after a growth step, both saturated at DEPTH
	logic [SUM_W-1:0] cap0_sum, cap0, grow_sum, grown_sat, cap1_sum, cap1;
	logic [SUM_W-1:0] fill_s, pos_s;
	logic             full0, full1, can_grow, push_ok, empty;

	assign cap0_sum  = SUM_W'(cfg.init_cap) + SUM_W'(grown_q);
	assign cap0      = (cap0_sum > DEPTH_S) ? DEPTH_S : cap0_sum;
	assign grow_sum  = SUM_W'(grown_q) + SUM_W'(cfg.grow_step);
	assign grown_sat = (grow_sum > DEPTH_S) ? DEPTH_S : grow_sum;
	assign cap1_sum  = SUM_W'(cfg.init_cap) + grown_sat;
	assign cap1      = (cap1_sum > DEPTH_S) ? DEPTH_S : cap1_sum;
	assign fill_s    = SUM_W'(fill_q);
	assign pos_s     = SUM_W'(pos_q);
	assign full0     = fill_s >= cap0;
	assign full1     = fill_s >= cap1;
	assign can_grow  = cfg.grow_step != '0;
	assign push_ok   = !full0 || (can_grow && !full1);
	assign empty     = fill_q == '0;
	assign fill_m1   = fill_q - 1'b1;

	// action decode
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_addr;
	logic              res_valid_d, res_ovf_d;
	logic [CW-1:0]     res_cnt_d;

	always_comb begin
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		mem_addr    = fill_q[ADDR_W-1:0];
		fill_d      = fill_q;
		grown_d     = grown_q;
		res_valid_d = 1'b0;
		res_cnt_d   = '0;
		res_ovf_d   = 1'b0;
		case (act_q)
			lsp_pkg::ACT_PUSH: begin
				if (full0 && can_grow) grown_d = CNT_W'(grown_sat);
				if (push_ok) begin
					mem_we    = 1'b1;
					fill_d    = fill_q + 1'b1;
					res_cnt_d = CW'(full0 ? cap1 : cap0);
				end else begin
					res_ovf_d = 1'b1;
				end
			end
			lsp_pkg::ACT_POP: begin
				if (!empty) begin
					mem_re      = 1'b1;
					mem_addr    = fill_m1[ADDR_W-1:0];
					fill_d      = fill_m1;
					res_valid_d = 1'b1;
					res_cnt_d   = CW'(fill_q);
				end
			end
			lsp_pkg::ACT_POKE: begin
				if (!empty) begin
					mem_we    = 1'b1;
					mem_addr  = fill_m1[ADDR_W-1:0];
					res_cnt_d = CW'(fill_q);
				end
			end
			lsp_pkg::ACT_PEEK: begin
				if (!empty) begin
					mem_re      = 1'b1;
					mem_addr    = fill_m1[ADDR_W-1:0];
					res_valid_d = 1'b1;
					res_cnt_d   = CW'(fill_q);
				end
			end
			lsp_pkg::ACT_PEEK_AT: begin
				// in range only below the fill count, which never exceeds DEPTH
				if (pos_s < fill_s) begin
					mem_re      = 1'b1;
					mem_addr    = ADDR_W'(pos_q);
					res_valid_d = 1'b1;
					res_cnt_d   = CW'(fill_q);
				end
			end
			default: ;
		endcase
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			grown_q <= '0;
		end else if (cmd.exec) begin
			fill_q  <= fill_d;
			grown_q <= grown_d;
		end
	end

	// stack memory, single port, registered read
	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.exec && mem_we) mem[mem_addr] <= word_q;
		if (cmd.exec && mem_re) rdata_q <= mem[mem_addr];
	end

	// result registers
	logic          res_valid_q, res_ovf_q;
	logic [CW-1:0] res_cnt_q;

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_valid_q <= res_valid_d;
			res_cnt_q   <= res_cnt_d;
			res_ovf_q   <= res_ovf_d;
		end
	end

	assign value_out      = res_valid_q ? VW'(rdata_q) : '0;
	assign value_valid    = res_valid_q;
	assign returned_count = res_cnt_q;
	assign overflow       = res_ovf_q;

	// checks
	assert property (@(posedge clk) disable iff (!arst_n) fill_s <= DEPTH_S)
		else $error("fill count above DEPTH");

	assert property (@(posedge clk) disable iff (!arst_n) SUM_W'(grown_q) <= DEPTH_S)
		else $error("growth above DEPTH");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && act_q == lsp_pkg::ACT_PUSH && push_ok)
			|=> fill_q == $past(fill_q) + 1'b1)
		else $error("accepted push did not raise the fill count");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && res_ovf_q) |-> (!res_valid_q && res_cnt_q == '0))
		else $error("refused push reported data or a count");

endmodule

`default_nettype wire

/* hw/rtl/lifo_stack_with_peek_poke_top.sv */
// Top level of the LIFO stack with peek and poke.
// Depends on lsp_pkg, lsp_cfg, lsp_ctrl and lsp_dp.
//
// Usage:
//   Request channel: action, value_in and index are taken at a rising edge
//   with start high and busy low. Actions: push, pop, poke (overwrite top),
//   peek (read top), peek_at (read by position from the bottom).
//   Result channel: done is high for exactly one cycle with value_out,
//   value_valid, returned_count and overflow; the receiver cannot stall it
//   and must take the result in that cycle.
//   Sequence: execute state after the accepting edge, then result state
//   with done high. Busy is high in the cycle after each accepting edge,
//   while the single-port stack memory is accessed and the counters
//   updated. A new request may be given while done is high.
//   Configuration: cfg_we, cfg_index, cfg_wdata write initial_capacity
//   (index 0) or grow_step (index 1) at once; the user must write them
//   only while no request is open, which the block does not enforce.
//   Reset: arst_n clears the fill count and growth and sets the registers to
//   capacity 256 and step 0; the memory is not cleared and needs no sweep.
`default_nettype none

module lifo_stack_with_peek_poke_top #(
	parameter int DEPTH      = lsp_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = lsp_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [lsp_pkg::ACT_W-1:0]       action,
	input  wire logic [lsp_pkg::VAL_W-1:0]       value_in,
	input  wire logic [lsp_pkg::POS_W-1:0]       index,
	output logic                                 done,
	output logic [lsp_pkg::VAL_W-1:0]            value_out,
	output logic                                 value_valid,
	output logic [lsp_pkg::CNT_OUT_W-1:0]        returned_count,
	output logic                                 overflow,
	input  wire logic                            cfg_we,
	input  wire logic [lsp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [lsp_pkg::CFG_W-1:0]       cfg_wdata
);

	lsp_pkg::cfg_t cfg;
	lsp_pkg::cmd_t cmd;

	lsp_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.idx    (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	lsp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	lsp_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg            (cfg),
		.action         (action),
		.value_in       (value_in),
		.index          (index),
		.value_out      (value_out),
		.value_valid    (value_valid),
		.returned_count (returned_count),
		.overflow       (overflow)
	);

endmodule

`default_nettype wire
